// File: design/first_fit_block_allocator_macros.svh
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FFBA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Check that a trigger implies a condition in the same cycle.
`define FFBA_ASSERT_IMPLIES(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that a trigger implies a condition in the next cycle.
`define FFBA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// File: design/ffba_pkg.sv
// Types and constants shared by the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int unsigned UNIT_W   = 20;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned SIZE_W   = 27;
    localparam int unsigned ALIGN_W  = 16;
    localparam int unsigned TOTAL_W  = 22;
    localparam int unsigned MALIGN_W = 13;

    localparam logic [ALIGN_W-1:0] MIN_ALIGN = 16'd16;
    localparam logic [ALIGN_W-1:0] MAX_ALIGN = 16'd4096;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOFIT     = 2'd1,
        ST_BADALIGN  = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef struct packed {
        logic                req_type;
        logic [SIZE_W-1:0]   req_size;
        logic [ALIGN_W-1:0]  req_align;
        logic [ADDR_W-1:0]   req_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [ADDR_W-1:0]   address;
    } t_rsp;

    typedef struct packed {
        logic [UNIT_W-1:0]   offset;
        logic [UNIT_W-1:0]   units;
        logic                free;
        logic [ADDR_W-1:0]   uaddr;
    } t_entry;

    typedef struct packed {
        logic                idle;
        logic                res_valid;
    } t_core_stat;

endpackage

// File: design/ffba_req_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [26:0] req_size;
    logic [15:0] req_align;
    logic [31:0] req_addr;

    modport source (output valid, req_type, req_size, req_align, req_addr, input ready);
    modport sink   (input valid, req_type, req_size, req_align, req_addr, output ready);
endinterface

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] address;

    modport source (output valid, status, address, input ready);
    modport sink   (input valid, status, address, output ready);
endinterface

// File: design/ffba_core.sv
// Block table memory and the sequencer that walks, splits and merges it.
`timescale 1ns / 1ps
module ffba_core #(
    parameter int unsigned HEAP_UNITS = 1048576,
    parameter int unsigned BLOCK_SLOTS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  ffba_pkg::t_req                 i_req,
    input  logic [25:0]                    i_base,
    input  logic                           i_out_free,
    output ffba_pkg::t_rsp                 o_res,
    output ffba_pkg::t_core_stat           o_stat,
    output logic [$clog2(BLOCK_SLOTS+1)-1:0] o_count
);
    import ffba_pkg::*;

    localparam int unsigned IW = $clog2(BLOCK_SLOTS);
    localparam int unsigned CW = $clog2(BLOCK_SLOTS + 1);

    typedef enum logic [11:0] {
        S_INIT  = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_CHECK = 12'b000000000100,
        S_RD    = 12'b000000001000,
        S_EV    = 12'b000000010000,
        S_NEXT  = 12'b000000100000,
        S_MERGE = 12'b000001000000,
        S_SH_RD = 12'b000010000000,
        S_SH_WR = 12'b000100000000,
        S_RAW   = 12'b001000000000,
        S_ADDR  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_entry r_mem [BLOCK_SLOTS];
    t_entry r_rdata;

    t_state                r_state;
    t_req                  r_req;
    logic [MALIGN_W-1:0]   r_align;
    logic [TOTAL_W-1:0]    r_total;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_f;
    logic [CW-1:0]         r_j;
    logic [1:0]            r_k;
    logic                  r_up;
    logic                  r_split;
    logic                  r_prev_ok;
    logic                  r_next_ok;
    t_entry                r_prev;
    t_entry                r_cur;
    t_entry                r_next;
    logic [ADDR_W-1:0]     r_raw;
    t_rsp                  r_res;
    logic                  r_res_valid;

    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    t_entry                w_wdata;
    logic [IW-1:0]         w_raddr;

    logic [ALIGN_W-1:0]    w_a16;
    logic                  w_bad;
    logic [SIZE_W-1:0]     w_size;
    logic [SIZE_W:0]       w_sum;
    logic                  w_fit;
    logic                  w_can_split;
    logic                  w_hit;
    logic                  w_pf;
    logic                  w_nf;
    logic [UNIT_W:0]       w_nx;
    logic [ADDR_W-1:0]     w_user;
    logic                  w_sh_done;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        w_a16 = (r_req.req_align < MIN_ALIGN) ? MIN_ALIGN : r_req.req_align;
        w_bad = ((w_a16 & (w_a16 - 16'd1)) != 16'd0) || (w_a16 > MAX_ALIGN);
        w_size = (r_req.req_size == '0) ? SIZE_W'(1) : r_req.req_size;
        w_sum = {1'b0, w_size} + (SIZE_W + 1)'(w_a16) + (SIZE_W + 1)'(78);
        w_fit = r_rdata.free && ({2'b00, r_rdata.units} >= r_total);
        w_can_split = ({3'b000, r_rdata.units} >= ({1'b0, r_total} + (TOTAL_W + 1)'(2)))
                      && (r_count < CW'(BLOCK_SLOTS));
        w_hit = !r_rdata.free && (r_rdata.uaddr == r_req.req_addr);
        w_pf = r_prev_ok && r_prev.free;
        w_nf = r_next_ok && r_next.free;
        w_nx = w_nf ? ((UNIT_W + 1)'(r_next.units) + (UNIT_W + 1)'(1)) : '0;
        w_user = (r_raw + 32'd15 + ADDR_W'(r_align)) & ~(ADDR_W'(r_align) - 32'd1);
        w_sh_done = r_up ? (r_j <= r_f) : (r_j >= r_count);
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_f[IW-1:0];
        w_wdata = r_cur;
        w_raddr = r_i[IW-1:0];
        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1;
                w_waddr = '0;
                w_wdata = '{offset: '0, units: UNIT_W'(HEAP_UNITS - 1), free: 1'b1, uaddr: '0};
            end
            S_EV: begin
                w_raddr = IW'(r_i + CW'(1));
            end
            S_MERGE: begin
                w_we = 1'b1;
                if (w_pf) begin
                    w_waddr = IW'(r_f - CW'(1));
                    w_wdata = r_prev;
                    w_wdata.units = UNIT_W'(r_prev.units + UNIT_W'(1) + r_cur.units + w_nx);
                end else begin
                    w_wdata = r_cur;
                    w_wdata.units = UNIT_W'(r_cur.units + w_nx);
                end
                w_wdata.free = 1'b1;
            end
            S_SH_RD: begin
                w_raddr = r_j[IW-1:0];
            end
            S_SH_WR: begin
                w_we = 1'b1;
                w_waddr = r_up ? IW'(r_j + CW'(1)) : IW'(r_j - CW'(r_k));
                w_wdata = r_rdata;
            end
            S_RAW: begin
                w_we = r_split;
                w_waddr = IW'(r_f + CW'(1));
                w_wdata.offset = UNIT_W'(r_cur.offset + UNIT_W'(1) + r_total[UNIT_W-1:0]);
                w_wdata.units = UNIT_W'(r_cur.units - r_total[UNIT_W-1:0] - UNIT_W'(1));
                w_wdata.free = 1'b1;
                w_wdata.uaddr = '0;
            end
            S_ADDR: begin
                w_we = 1'b1;
                w_wdata = r_cur;
                if (r_split) begin
                    w_wdata.units = r_total[UNIT_W-1:0];
                end
                w_wdata.free = 1'b0;
                w_wdata.uaddr = w_user;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_req <= i_req;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_i <= '0;
                    r_prev_ok <= 1'b0;
                    r_next_ok <= 1'b0;
                    r_split <= 1'b0;
                    r_align <= w_a16[MALIGN_W-1:0];
                    r_total <= w_sum[SIZE_W:6];
                    r_res.address <= '0;
                    if (r_req.req_type == REQ_ALLOC && w_bad) begin
                        r_res.status <= ST_BADALIGN;
                        r_state <= S_DONE;
                    end else if (r_req.req_type == REQ_FREE && r_req.req_addr == '0) begin
                        r_res.status <= ST_IGNORED;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_i >= r_count) begin
                        r_res.status <= (r_req.req_type == REQ_ALLOC) ? ST_NOFIT : ST_IGNORED;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EV;
                    end
                end
                S_EV: begin
                    r_f <= r_i;
                    r_cur <= r_rdata;
                    if (r_req.req_type == REQ_ALLOC && w_fit) begin
                        r_split <= w_can_split;
                        r_up <= 1'b1;
                        r_j <= r_count - CW'(1);
                        r_state <= w_can_split ? S_SH_RD : S_RAW;
                    end else if (r_req.req_type == REQ_FREE && w_hit) begin
                        if ((r_i + CW'(1)) < r_count) begin
                            r_next_ok <= 1'b1;
                            r_state <= S_NEXT;
                        end else begin
                            r_state <= S_MERGE;
                        end
                    end else begin
                        r_prev <= r_rdata;
                        r_prev_ok <= 1'b1;
                        r_i <= r_i + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_NEXT: begin
                    r_next <= r_rdata;
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_res.status <= ST_DONE;
                    r_up <= 1'b0;
                    r_k <= {1'b0, w_pf} + {1'b0, w_nf};
                    r_j <= r_f + CW'(1) + CW'(w_nf);
                    r_state <= (w_pf || w_nf) ? S_SH_RD : S_DONE;
                end
                S_SH_RD: begin
                    if (w_sh_done) begin
                        if (r_up) begin
                            r_state <= S_RAW;
                        end else begin
                            r_count <= r_count - CW'(r_k);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_j <= r_up ? (r_j - CW'(1)) : (r_j + CW'(1));
                    r_state <= S_SH_RD;
                end
                S_RAW: begin
                    r_raw <= {i_base, 6'b000000}
                             + ((ADDR_W'(r_cur.offset) + 32'd1) << 6);
                    if (r_split) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_res.status <= ST_DONE;
                    r_res.address <= w_user;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_res_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res = r_res;
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.res_valid = r_res_valid;
    assign o_count = r_count;

endmodule

// File: design/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: register port, channels and result register.
// Requests are taken one at a time. The block table sits in a single-port-write,
// single-port-read memory, so each table entry visited passes through an address state
// and then a compare state. An allocate walks up to the first free block that fits, and a
// split moves every later entry up by one, each through a read state and a write state. A
// free walks up to the matching live block, reads its neighbor, and a merge moves later
// entries down the same way. The entries walked plus the entries moved never exceed the
// block count. After reset the block seeds the table in its init state before the request
// channel opens.
// The result sits in an output register, so the next request is taken while it waits.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
    parameter int unsigned HEAP_UNITS = 1048576,
    parameter int unsigned BLOCK_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffba_pkg::*;

    localparam int unsigned CW = $clog2(BLOCK_SLOTS + 1);

    logic [25:0]   r_base;
    logic          r_out_valid;
    t_rsp          r_out;
    t_req          w_req;
    t_rsp          w_res;
    t_core_stat    w_stat;
    logic [CW-1:0] w_count;
    logic          w_out_free;
    logic          w_start;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {r_base, 6'b000000} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_base <= pwdata[31:6];
        end
    end

    assign w_req.req_type  = i_req.req_type;
    assign w_req.req_size  = i_req.req_size;
    assign w_req.req_align = i_req.req_align;
    assign w_req.req_addr  = i_req.req_addr;
    assign i_req.ready     = w_stat.idle;
    assign w_start         = i_req.valid && w_stat.idle;
    assign w_out_free      = !r_out_valid || o_rsp.ready;

    ffba_core #(
        .HEAP_UNITS(HEAP_UNITS),
        .BLOCK_SLOTS(BLOCK_SLOTS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_req     (w_req),
        .i_base    (r_base),
        .i_out_free(w_out_free),
        .o_res     (w_res),
        .o_stat    (w_stat),
        .o_count   (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out.status;
    assign o_rsp.address = r_out.address;

`include "first_fit_block_allocator_macros.svh"

    `FFBA_ASSERT_NEXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    `FFBA_ASSERT_ALWAYS(a_count_range, w_count != '0 && w_count <= CW'(BLOCK_SLOTS))
    `FFBA_ASSERT_IMPLIES(a_fail_no_addr, o_rsp.valid && o_rsp.status != ST_DONE, o_rsp.address == '0)
    `FFBA_ASSERT_NEXT(a_result_lands, w_stat.res_valid, o_rsp.valid)

endmodule

// File: sim/tb.sv
// Self-checking testbench for the first-fit block allocator with a scoreboard class.
`timescale 1ns / 1ps
module tb;
    import ffba_pkg::*;

    localparam int unsigned HEAP_UNITS    = 1048576;
    localparam int unsigned BLOCK_SLOTS   = 256;
    localparam logic [2:0]  REG_HEAP_BASE = 3'd0;
    localparam logic [2:0]  REG_UNUSED    = 3'd4;
    localparam int unsigned DRAIN_CYCLES  = 4 * BLOCK_SLOTS + 64;
    localparam longint      CYCLE_LIMIT   = 20000000;

    typedef struct {
        t_status     status;
        logic [31:0] address;
    } t_expect;

    class heap_scoreboard;
        logic [31:0] base;
        logic [19:0] offset [BLOCK_SLOTS];
        logic [19:0] units  [BLOCK_SLOTS];
        bit          free   [BLOCK_SLOTS];
        logic [31:0] uaddr  [BLOCK_SLOTS];
        int unsigned count;
        t_expect     expected_q[$];
        int unsigned errors;
        int unsigned n_alloc;
        int unsigned n_free;
        int unsigned n_full;

        function new();
            base = '0;
            count = 1;
            errors = 0;
            n_alloc = 0;
            n_free = 0;
            n_full = 0;
            foreach (offset[i]) begin
                offset[i] = '0;
                units[i]  = '0;
                free[i]   = 0;
                uaddr[i]  = '0;
            end
            units[0] = 20'(HEAP_UNITS - 1);
            free[0]  = 1;
        endfunction

        function void set_base(logic [31:0] value);
            base = value & 32'hFFFF_FFC0;
        endfunction

        function void merge_runs();
            int unsigned i;
            i = 0;
            while (i + 1 < count) begin
                if (free[i] && free[i+1]) begin
                    units[i] = units[i] + 20'd1 + units[i+1];
                    for (int unsigned j = i + 1; j + 1 < count; j++) begin
                        offset[j] = offset[j+1];
                        units[j]  = units[j+1];
                        free[j]   = free[j+1];
                        uaddr[j]  = uaddr[j+1];
                    end
                    count--;
                end else begin
                    i++;
                end
            end
        endfunction

        function t_expect predict(t_req req);
            t_expect         res;
            longint unsigned sz;
            longint unsigned al;
            longint unsigned total;
            longint unsigned raw;
            longint unsigned usr;
            res.status  = ST_DONE;
            res.address = '0;
            if (req.req_type == REQ_ALLOC) begin
                n_alloc++;
                sz = req.req_size;
                al = req.req_align;
                if (sz == 0) sz = 1;
                if (al < MIN_ALIGN) al = MIN_ALIGN;
                if ((al & (al - 1)) != 0 || al > MAX_ALIGN) begin
                    res.status = ST_BADALIGN;
                    return res;
                end
                total = (sz + al - 1 + 16 + 63) / 64;
                for (int unsigned i = 0; i < count; i++) begin
                    if (!free[i] || units[i] < total) continue;
                    if (units[i] >= total + 2 && count < BLOCK_SLOTS) begin
                        for (int unsigned j = count; j > i + 1; j--) begin
                            offset[j] = offset[j-1];
                            units[j]  = units[j-1];
                            free[j]   = free[j-1];
                            uaddr[j]  = uaddr[j-1];
                        end
                        offset[i+1] = offset[i] + 20'd1 + total[19:0];
                        units[i+1]  = units[i] - total[19:0] - 20'd1;
                        free[i+1]   = 1;
                        uaddr[i+1]  = '0;
                        units[i]    = total[19:0];
                        count++;
                    end else if (count == BLOCK_SLOTS) begin
                        n_full++;
                    end
                    free[i] = 0;
                    raw = longint'(base) + (longint'(offset[i]) + 1) * 64;
                    usr = (raw + 16 + al - 1) & ~(al - 1);
                    uaddr[i] = usr[31:0];
                    res.address = usr[31:0];
                    return res;
                end
                res.status = ST_NOFIT;
                return res;
            end
            n_free++;
            if (req.req_addr != 0) begin
                for (int unsigned i = 0; i < count; i++) begin
                    if (!free[i] && uaddr[i] == req.req_addr) begin
                        free[i] = 1;
                        merge_runs();
                        return res;
                    end
                end
            end
            res.status = ST_IGNORED;
            return res;
        endfunction

        function void note_request(t_req req);
            expected_q.push_back(predict(req));
        endfunction

        function void check_response(logic [1:0] status, logic [31:0] address);
            t_expect exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected response status=%0d address=%h",
                         $time, status, address);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (status !== exp_res.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, exp_res.status, status);
                errors++;
            end
            if (address !== exp_res.address) begin
                $display("%0t: address mismatch expected=%h actual=%h",
                         $time, exp_res.address, address);
                errors++;
            end
        endfunction

        function logic [31:0] pick_live();
            int unsigned live[$];
            for (int unsigned i = 0; i < count; i++)
                if (!free[i]) live.push_back(i);
            if (live.size() == 0) return 32'h0;
            return uaddr[live[$urandom_range(live.size() - 1)]];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator #(
        .HEAP_UNITS  (HEAP_UNITS),
        .BLOCK_SLOTS (BLOCK_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    heap_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    int unsigned    hold_request;
    longint         cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.address);
    end

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_HEAP_BASE) sb.set_base(data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_request(t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= req.req_type;
        req_ch.req_size  <= req.req_size;
        req_ch.req_align <= req.req_align;
        req_ch.req_addr  <= req.req_addr;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(req);
    endtask

    task automatic send_alloc(logic [26:0] size, logic [15:0] align);
        t_req req;
        req.req_type  = REQ_ALLOC;
        req.req_size  = size;
        req.req_align = align;
        req.req_addr  = $urandom;
        send_request(req);
    endtask

    task automatic send_free(logic [31:0] addr);
        t_req req;
        req.req_type  = REQ_FREE;
        req.req_size  = 27'($urandom);
        req.req_align = 16'($urandom);
        req.req_addr  = addr;
        send_request(req);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [31:0] addr;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_alloc(27'($urandom_range(1500)), 16'(1 << $urandom_range(12)));
        end else if (pick < 62) begin
            send_alloc(27'($urandom_range(200000)), 16'($urandom_range(4096)));
        end else if (pick < 65) begin
            send_alloc(27'($urandom), 16'($urandom));
        end else if (pick < 92) begin
            send_free(sb.pick_live());
        end else if (pick < 96) begin
            send_free($urandom);
        end else begin
            addr = sb.pick_live();
            send_free(addr);
            send_free(addr);
        end
    endtask

    initial begin : stimulus
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] bases [4];
        int unsigned idle_s [4];
        int unsigned idle_r [4];
        sb = new();
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_ALLOC;
        req_ch.req_size  = '0;
        req_ch.req_align = '0;
        req_ch.req_addr  = '0;
        rsp_ch.ready     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_write(REG_UNUSED, 32'hDEAD_BEEF);
        send_alloc(27'd0, 16'd0);
        send_alloc(27'd1, 16'd4096);
        send_alloc(27'd100, 16'd8192);
        send_alloc(27'd100, 16'hFFFF);
        send_alloc(27'd100, 16'd48);
        send_alloc(27'd100, 16'd3);
        send_alloc(27'd67108864, 16'd16);
        send_alloc(27'h7FF_FFFF, 16'd16);
        send_free(32'h0);
        send_free(32'hFFFF_FFFF);
        a0 = sb.pick_live();
        send_free(a0);
        send_free(a0);
        send_alloc(27'd67000000, 16'd64);
        drain();

        apb_write(REG_HEAP_BASE, 32'hFFFF_FFFF);
        send_alloc(27'd5000, 16'd4096);
        send_alloc(27'd1, 16'd32);
        a1 = sb.pick_live();
        drain();
        apb_write(REG_HEAP_BASE, 32'h0000_1234);
        send_free(a1);
        send_alloc(27'd64, 16'd0);
        drain();

        bases  = '{32'h0, $urandom, 32'hFFFF_FFC0, $urandom};
        idle_s = '{0, 79, 0, 23};
        idle_r = '{0, 0, 79, 23};
        for (int p = 0; p < 4; p++) begin
            apb_write(REG_HEAP_BASE, bases[p]);
            send_idle_pct  = idle_s[p];
            recv_stall_pct = idle_r[p];
            for (int n = 0; n < 380; n++) begin
                if (p == 0 && n == 100) hold_request = 3000;
                if (n == 200) begin
                    @(negedge i_clk);
                    req_ch.valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge i_clk);
                end
                random_item();
            end
            drain();
        end

        $display("Covered %0d allocate and %0d free requests, %0d on a full table,",
                 sb.n_alloc, sb.n_free, sb.n_full);
        $display("across four heap bases and four idle and stall mixes.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
